[hw/rtl/utf8v_pkg.sv]
// Package for the UTF-8 text validator: error codes, verdict struct and byte constants.
// Depends on nothing; used by utf8v_core, utf8_text_validator_unit and the testbench.
package utf8v_pkg;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_LEAD      = 4'd1,
        ERR_CONT      = 4'd2,
        ERR_TRUNC     = 4'd3,
        ERR_OVERLONG  = 4'd4,
        ERR_SURROGATE = 4'd5,
        ERR_ABOVE     = 4'd6,
        ERR_NUL       = 4'd7,
        ERR_TOO_LONG  = 4'd8,
        ERR_EMPTY     = 4'd9
    } t_err;

    typedef struct packed {
        logic valid_res;
        t_err error_kind;
    } t_verdict;

    // Configuration register indexes
    typedef enum logic {
        REG_MAX_LENGTH       = 1'b0,
        REG_REQUIRE_NONEMPTY = 1'b1
    } t_reg;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] ASCII_END = 8'h80;

    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;

endpackage

[hw/rtl/utf8v_if.sv]
// Stream interfaces of the UTF-8 text validator: text bytes in, verdicts out.
// Depends on nothing beyond plain logic types.
interface utf8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       empty_string;

    modport source (output valid, output data_byte, output last, output empty_string,
                    input ready);
    modport sink   (input valid, input data_byte, input last, input empty_string,
                    output ready);
endinterface

interface utf8v_out_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [3:0] error_kind;

    modport source (output valid, output valid_res, output error_kind, input ready);
    modport sink   (input valid, input valid_res, input error_kind, output ready);
endinterface

[hw/rtl/utf8v_core.sv]
// Per-string decode state and its per-item update for the UTF-8 text validator.
// Depends on utf8v_pkg.
module utf8v_core #(
    parameter int LENGTH_BITS = 16,
    parameter int MLW         = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic                   i_empty,
    input  logic [MLW-1:0]         i_max_length,
    input  logic                   i_require_nonempty,
    output utf8v_pkg::t_verdict    o_res
);

    localparam int CW = LENGTH_BITS + 1;
    localparam logic [CW-1:0] CNT_MAX = '1;

    logic [1:0]      r_pend, n_pend;
    logic [2:0]      r_seq, n_seq;
    logic [20:0]     r_acc, n_acc;
    logic [CW-1:0]   r_cnt, n_cnt;
    utf8v_pkg::t_err r_fe, n_fe, err;
    logic [20:0]     acc_sh;
    logic [1:0]      pend_dec;
    logic [CW-1:0]   max_ext;
    logic            ends;

    assign acc_sh   = {r_acc[14:0], i_byte[5:0]};
    assign pend_dec = r_pend - 2'd1;
    assign max_ext  = {{(CW-MLW){1'b0}}, i_max_length};
    assign ends     = i_empty | i_last;

    always_comb begin
        n_pend = r_pend;
        n_seq  = r_seq;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        err    = utf8v_pkg::ERR_NONE;
        if (i_empty) begin
            // empty item after bytes closes the string, flagging an open sequence as truncated
            if (r_cnt == '0) begin
                if (i_require_nonempty) begin
                    err = utf8v_pkg::ERR_EMPTY;
                end
            end else if (r_pend != 2'd0) begin
                err = utf8v_pkg::ERR_TRUNC;
            end
        end else begin
            n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CW'(1);
            if (r_fe == utf8v_pkg::ERR_NONE) begin
                priority if (n_cnt > max_ext) begin
                    err = utf8v_pkg::ERR_TOO_LONG;
                end else if (i_byte == 8'h00) begin
                    err = utf8v_pkg::ERR_NUL;
                end else if (r_pend == 2'd0) begin
                    priority if (i_byte < utf8v_pkg::ASCII_END) begin
                        n_pend = 2'd0;
                    end else if (i_byte >= utf8v_pkg::LEAD2_LO &&
                                 i_byte <= utf8v_pkg::LEAD2_HI) begin
                        n_pend = 2'd1;
                        n_seq  = 3'd2;
                        n_acc  = {16'd0, i_byte[4:0]};
                    end else if (i_byte >= utf8v_pkg::LEAD3_LO &&
                                 i_byte <= utf8v_pkg::LEAD3_HI) begin
                        n_pend = 2'd2;
                        n_seq  = 3'd3;
                        n_acc  = {17'd0, i_byte[3:0]};
                    end else if (i_byte >= utf8v_pkg::LEAD4_LO &&
                                 i_byte <= utf8v_pkg::LEAD4_HI) begin
                        n_pend = 2'd3;
                        n_seq  = 3'd4;
                        n_acc  = {18'd0, i_byte[2:0]};
                    end else begin
                        err = utf8v_pkg::ERR_LEAD;
                    end
                end else if (i_byte[7:6] != 2'b10) begin
                    err = utf8v_pkg::ERR_CONT;
                end else begin
                    n_acc  = acc_sh;
                    n_pend = pend_dec;
                    if (pend_dec == 2'd0) begin
                        // sequence complete: range checks on the code point
                        priority if ((r_seq == 3'd3 && acc_sh < utf8v_pkg::CP_MIN3) ||
                                     (r_seq == 3'd4 && acc_sh < utf8v_pkg::CP_MIN4)) begin
                            err = utf8v_pkg::ERR_OVERLONG;
                        end else if (acc_sh > utf8v_pkg::CP_MAX) begin
                            err = utf8v_pkg::ERR_ABOVE;
                        end else if (acc_sh >= utf8v_pkg::CP_SURR_LO &&
                                     acc_sh <= utf8v_pkg::CP_SURR_HI) begin
                            err = utf8v_pkg::ERR_SURROGATE;
                        end else begin
                            err = utf8v_pkg::ERR_NONE;
                        end
                        n_seq = 3'd0;
                        n_acc = 21'd0;
                    end
                end
            end
            if (i_last && n_pend != 2'd0 && err == utf8v_pkg::ERR_NONE) begin
                err = utf8v_pkg::ERR_TRUNC;
            end
        end
        n_fe = (r_fe == utf8v_pkg::ERR_NONE) ? err : r_fe;
    end

    assign o_res.valid_res  = (n_fe == utf8v_pkg::ERR_NONE);
    assign o_res.error_kind = n_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_seq  <= 3'd0;
            r_acc  <= 21'd0;
            r_cnt  <= '0;
            r_fe   <= utf8v_pkg::ERR_NONE;
        end else if (i_step) begin
            if (ends) begin
                r_pend <= 2'd0;
                r_seq  <= 3'd0;
                r_acc  <= 21'd0;
                r_cnt  <= '0;
                r_fe   <= utf8v_pkg::ERR_NONE;
            end else begin
                r_pend <= n_pend;
                r_seq  <= n_seq;
                r_acc  <= n_acc;
                r_cnt  <= n_cnt;
                r_fe   <= n_fe;
            end
        end
    end

    // continuations still due never reach the sequence length
    a_seq_tracks_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd0 |-> (r_seq > {1'b0, r_pend} && r_seq <= 3'd4))
        else $error("sequence length out of step with pending count");

    a_idle_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == 2'd0 |-> (r_seq == 3'd0 && r_acc == 21'd0))
        else $error("decode state left over outside a sequence");

    a_no_error_before_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_fe == utf8v_pkg::ERR_NONE)
        else $error("error recorded with no bytes counted");

endmodule

[hw/rtl/utf8_text_validator_unit.sv]
// Strict UTF-8 string validator. Takes one byte item per cycle (a new item can be
// accepted every clock unless the input is stalled) and gives a verdict item on the
// byte flagged last or on an empty_string item. The rate is set by the per-item update
// of the decode state in utf8v_core; an ending item passes the input register, then
// the result register, before its verdict is presented.
// A held-off verdict only stalls the input when a second ending item is waiting in
// the input register.
// Depends on utf8v_pkg, utf8v_in_if/utf8v_out_if and utf8v_core.
module utf8_text_validator_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8v_in_if.sink             i_text,
    utf8v_out_if.source          o_verdict,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // max_length is held modulo 2^MLW, MLW being LENGTH_BITS capped at 16
    localparam int MLW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

    logic [MLW-1:0]      r_max_length;
    logic                r_require_nonempty;
    logic                r_s1_valid;
    logic [7:0]          r_s1_byte;
    logic                r_s1_last;
    logic                r_s1_empty;
    logic                r_out_valid;
    utf8v_pkg::t_verdict r_out;
    utf8v_pkg::t_verdict core_res;
    logic                s1_ends;
    logic                s1_go;
    logic                in_ready;
    logic                cfg_wr;

    // ---- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (utf8v_pkg::t_reg'(paddr[2]))
            utf8v_pkg::REG_MAX_LENGTH:
                prdata = {{(32-MLW){1'b0}}, r_max_length};
            utf8v_pkg::REG_REQUIRE_NONEMPTY:
                prdata = {31'd0, r_require_nonempty};
            default:
                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length       <= '1;
            r_require_nonempty <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == utf8v_pkg::REG_MAX_LENGTH) begin
                r_max_length <= pwdata[MLW-1:0];
            end else begin
                r_require_nonempty <= pwdata[0];
            end
        end
    end

    // ---- input register and handshake
    assign s1_ends  = r_s1_empty | r_s1_last;
    assign s1_go    = r_s1_valid & (~s1_ends | ~r_out_valid | o_verdict.ready);
    assign in_ready = ~r_s1_valid | s1_go;
    assign i_text.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_text.valid) begin
            r_s1_byte  <= i_text.data_byte;
            r_s1_last  <= i_text.last;
            r_s1_empty <= i_text.empty_string;
        end
    end

    utf8v_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .MLW         (MLW)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (s1_go),
        .i_byte             (r_s1_byte),
        .i_last             (r_s1_last),
        .i_empty            (r_s1_empty),
        .i_max_length       (r_max_length),
        .i_require_nonempty (r_require_nonempty),
        .o_res              (core_res)
    );

    // ---- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_ends) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_ends) begin
            r_out <= core_res;
        end
    end

    assign o_verdict.valid      = r_out_valid;
    assign o_verdict.valid_res  = r_out.valid_res;
    assign o_verdict.error_kind = r_out.error_kind;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && s1_ends && r_out_valid))
        else $error("input held off without a blocked verdict");

    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_byte) &&
                                   $stable(r_s1_last) && $stable(r_s1_empty)))
        else $error("stalled item lost or changed in input register");

    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.valid_res == (r_out.error_kind == utf8v_pkg::ERR_NONE)))
        else $error("verdict flag disagrees with error kind");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for utf8_text_validator_unit: random and directed strings,
// APB register writes with read-back, and a verdict predictor kept in step with the block.
// Depends on utf8v_pkg, the utf8v_in_if/utf8v_out_if interfaces and the RTL top level.
module tb_top;

    localparam int LEN_BITS    = 16;
    localparam int HALF_CLK    = 5;
    localparam int SETTLE_CYC  = 8;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       empty_string;
    } t_text_item;

    // how a string is closed
    typedef enum int { END_LAST, END_EMPTY, END_BOTH } t_end;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    utf8v_in_if  txt();
    utf8v_out_if vrd();

    utf8_text_validator_unit #(.LENGTH_BITS(LEN_BITS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (txt),
        .o_verdict (vrd),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #HALF_CLK i_clk = ~i_clk;

    // predictor: register copies and per-string decode state
    logic [15:0]       lim_len;
    logic              want_text;
    logic [1:0]        cp_pend;
    logic [2:0]        cp_len;
    logic [20:0]       cp_acc;
    logic [LEN_BITS:0] str_count;
    utf8v_pkg::t_err   str_err;

    t_text_item          text_q[$];
    utf8v_pkg::t_verdict verdict_q[$];
    logic [7:0]          str_buf[$];

    logic        in_taken = 1'b0;
    bit          quiet = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          n_fail = 0;
    int          n_checked = 0;
    int          n_valid = 0;
    int          n_accepted = 0;
    int          n_pushed = 0;
    logic [9:0]  kinds_seen = '0;

    function automatic void flag_fail(string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void note_err(utf8v_pkg::t_err kind);
        if (str_err == utf8v_pkg::ERR_NONE)
            str_err = kind;
    endfunction

    function automatic void clear_str();
        cp_pend   = '0;
        cp_len    = '0;
        cp_acc    = '0;
        str_count = '0;
        str_err   = utf8v_pkg::ERR_NONE;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        if (cp_pend == 2'd0) begin
            if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
                cp_pend = 2'd1;
                cp_len  = 3'd2;
                cp_acc  = {16'd0, b[4:0]};
            end else if (b >= utf8v_pkg::LEAD3_LO && b <= utf8v_pkg::LEAD3_HI) begin
                cp_pend = 2'd2;
                cp_len  = 3'd3;
                cp_acc  = {17'd0, b[3:0]};
            end else if (b >= utf8v_pkg::LEAD4_LO && b <= utf8v_pkg::LEAD4_HI) begin
                cp_pend = 2'd3;
                cp_len  = 3'd4;
                cp_acc  = {18'd0, b[2:0]};
            end else if (b >= utf8v_pkg::ASCII_END) begin
                note_err(utf8v_pkg::ERR_LEAD);
            end
        end else if (b[7:6] != 2'b10) begin
            note_err(utf8v_pkg::ERR_CONT);
        end else begin
            cp_acc  = {cp_acc[14:0], b[5:0]};
            cp_pend = cp_pend - 2'd1;
            if (cp_pend == 2'd0) begin
                // overlong before above-max before surrogate
                if ((cp_len == 3'd3 && cp_acc < utf8v_pkg::CP_MIN3) ||
                    (cp_len == 3'd4 && cp_acc < utf8v_pkg::CP_MIN4))
                    note_err(utf8v_pkg::ERR_OVERLONG);
                else if (cp_acc > utf8v_pkg::CP_MAX)
                    note_err(utf8v_pkg::ERR_ABOVE);
                else if (cp_acc >= utf8v_pkg::CP_SURR_LO && cp_acc <= utf8v_pkg::CP_SURR_HI)
                    note_err(utf8v_pkg::ERR_SURROGATE);
                cp_len = '0;
                cp_acc = '0;
            end
        end
    endfunction

    // returns 1 when the item closes a string, with the verdict in v
    function automatic bit text_step(t_text_item it, output utf8v_pkg::t_verdict v);
        if (it.empty_string) begin
            if (str_count == '0) begin
                if (want_text)
                    note_err(utf8v_pkg::ERR_EMPTY);
            end else if (cp_pend != 2'd0) begin
                note_err(utf8v_pkg::ERR_TRUNC);
            end
        end else begin
            if (str_count != '1)
                str_count++;
            if (str_err == utf8v_pkg::ERR_NONE) begin
                if (str_count > {1'b0, lim_len})
                    note_err(utf8v_pkg::ERR_TOO_LONG);
                else if (it.data_byte == 8'h00)
                    note_err(utf8v_pkg::ERR_NUL);
                else
                    decode_byte(it.data_byte);
            end
            if (!it.last)
                return 1'b0;
            if (cp_pend != 2'd0)
                note_err(utf8v_pkg::ERR_TRUNC);
        end
        v.valid_res  = (str_err == utf8v_pkg::ERR_NONE);
        v.error_kind = str_err;
        clear_str();
        return 1'b1;
    endfunction

    // shortest encoding, so surrogates and values above the limit come out as such
    function automatic void add_cp(logic [20:0] cp);
        if (cp < 21'h80) begin
            str_buf.push_back(cp[7:0]);
        end else if (cp < utf8v_pkg::CP_MIN3) begin
            str_buf.push_back({3'b110, cp[10:6]});
            str_buf.push_back({2'b10, cp[5:0]});
        end else if (cp < utf8v_pkg::CP_MIN4) begin
            str_buf.push_back({4'b1110, cp[15:12]});
            str_buf.push_back({2'b10, cp[11:6]});
            str_buf.push_back({2'b10, cp[5:0]});
        end else begin
            str_buf.push_back({5'b11110, cp[20:18]});
            str_buf.push_back({2'b10, cp[17:12]});
            str_buf.push_back({2'b10, cp[11:6]});
            str_buf.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void send_string(t_end how);
        t_text_item it;
        foreach (str_buf[k]) begin
            it.data_byte    = str_buf[k];
            it.last         = (how == END_LAST) && (k == str_buf.size() - 1);
            it.empty_string = 1'b0;
            text_q.push_back(it);
            n_pushed++;
        end
        if (how != END_LAST || str_buf.size() == 0) begin
            it.data_byte    = 8'($urandom_range(0, 255));
            it.last         = (how == END_BOTH);
            it.empty_string = 1'b1;
            text_q.push_back(it);
            n_pushed++;
        end
    endfunction

    function automatic logic [20:0] rand_cp();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(1, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: begin
                // skip the surrogate block
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= utf8v_pkg::CP_SURR_LO)
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    function automatic void corrupt_string();
        int pos;
        pos = $urandom_range(0, str_buf.size());
        case ($urandom_range(0, 7))
            0: str_buf.insert(pos, 8'($urandom_range(0, 255)));
            1: if (str_buf.size() > 0) str_buf.pop_back();
            2: str_buf.insert(pos, 8'h00);
            3: begin
                str_buf.push_back(utf8v_pkg::LEAD3_LO);
                str_buf.push_back(8'($urandom_range('h80, 'h9F)));
                str_buf.push_back(8'($urandom_range('h80, 'hBF)));
            end
            4: begin
                str_buf.push_back(utf8v_pkg::LEAD4_LO);
                str_buf.push_back(8'($urandom_range('h80, 'h8F)));
                str_buf.push_back(8'($urandom_range('h80, 'hBF)));
                str_buf.push_back(8'($urandom_range('h80, 'hBF)));
            end
            5: add_cp(21'($urandom_range(utf8v_pkg::CP_SURR_LO, utf8v_pkg::CP_SURR_HI)));
            6: add_cp(21'($urandom_range('h110000, 'h1FFFFF)));
            default: begin
                if ($urandom_range(0, 1))
                    str_buf.insert(pos, 8'($urandom_range('h80, 'hC1)));
                else
                    str_buf.insert(pos, 8'($urandom_range('hF5, 'hFF)));
            end
        endcase
    endfunction

    function automatic void rand_string();
        int   n;
        t_end how;
        str_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) str_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 5);
            repeat (n) add_cp(rand_cp());
            if ($urandom_range(0, 3) == 0)
                corrupt_string();
        end
        case ($urandom_range(0, 9))
            7, 8:    how = END_EMPTY;
            9:       how = END_BOTH;
            default: how = END_LAST;
        endcase
        send_string(how);
    endfunction

    function automatic void run_random(int n_items);
        int target;
        target = n_pushed + n_items;
        while (n_pushed < target)
            rand_string();
    endfunction

    // all items taken and all verdicts in, then let the pipeline settle
    task automatic drain();
        while (n_accepted != n_pushed || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic cfg_write(utf8v_pkg::t_reg idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        mask = (idx == utf8v_pkg::REG_MAX_LENGTH) ? 32'h0000_FFFF : 32'h0000_0001;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        // read back straight after the write
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((rd & mask) != (value & mask))
            flag_fail($sformatf("register %s read back %0h, wrote %0h",
                                idx.name(), rd & mask, value & mask));
        if (idx == utf8v_pkg::REG_MAX_LENGTH)
            lim_len = value[15:0];
        else
            want_text = value[0];
    endtask

    // byte item driver
    always @(negedge i_clk) begin
        t_text_item nxt;
        if (i_rst_n && (!txt.valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                txt.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(0, 7);
                txt.valid <= 1'b0;
            end else if (text_q.size() > 0) begin
                nxt = text_q.pop_front();
                txt.valid        <= 1'b1;
                txt.data_byte    <= nxt.data_byte;
                txt.last         <= nxt.last;
                txt.empty_string <= nxt.empty_string;
            end else begin
                txt.valid <= 1'b0;
            end
        end
    end

    // verdict back-pressure
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            recv_stall--;
            vrd.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_stall = $urandom_range(0, 7);
            vrd.ready <= 1'b0;
        end else begin
            vrd.ready <= 1'b1;
        end
    end

    // monitor: check verdicts, then predict from the accepted item
    always @(posedge i_clk) begin
        utf8v_pkg::t_verdict want;
        t_text_item          cur;
        in_taken <= i_rst_n && txt.valid && txt.ready;
        if (i_rst_n) begin
            if (vrd.valid && vrd.ready) begin
                if (verdict_q.size() == 0) begin
                    flag_fail($sformatf("verdict valid_res=%0d kind=%0d with none expected",
                                        vrd.valid_res, vrd.error_kind));
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    if (vrd.valid_res !== want.valid_res || vrd.error_kind !== want.error_kind)
                        flag_fail($sformatf(
                            "verdict %0d: expected valid_res=%0d kind=%0d, got %0d kind=%0d",
                            n_checked, want.valid_res, want.error_kind,
                            vrd.valid_res, vrd.error_kind));
                end
            end
            if (txt.valid && txt.ready) begin
                cur = {txt.data_byte, txt.last, txt.empty_string};
                n_accepted++;
                if (text_step(cur, want)) begin
                    verdict_q.push_back(want);
                    kinds_seen[want.error_kind] = 1'b1;
                    if (want.valid_res)
                        n_valid++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d of %0d items taken, %0d verdicts outstanding",
                 n_accepted, n_pushed, verdict_q.size());
        $display("utf8_text_validator_unit regression: fail");
        $finish;
    end

    initial begin
        logic [15:0] lim;
        logic        nonempty;
        txt.valid        = 1'b0;
        txt.data_byte    = 8'h00;
        txt.last         = 1'b0;
        txt.empty_string = 1'b0;
        vrd.ready        = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        lim_len          = 16'hFFFF;
        want_text        = 1'b1;
        clear_str();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings under the reset settings
        str_buf.delete();
        send_string(END_EMPTY);                         // empty string rejected
        str_buf = '{8'h7F};
        send_string(END_LAST);
        str_buf = '{8'h00};
        send_string(END_LAST);                          // NUL
        str_buf = '{8'hDF, 8'hBF};
        send_string(END_LAST);
        str_buf = '{utf8v_pkg::LEAD3_LO, 8'h80, 8'h80};
        send_string(END_LAST);                          // three-byte overlong
        str_buf = '{8'hED, 8'hA0, 8'h80};
        send_string(END_LAST);                          // surrogate
        str_buf = '{utf8v_pkg::LEAD4_HI, 8'h90, 8'h80, 8'h80};
        send_string(END_LAST);                          // above U+10FFFF
        str_buf = '{utf8v_pkg::LEAD4_HI, 8'h8F, 8'hBF, 8'hBF};
        send_string(END_LAST);                          // highest code point
        str_buf = '{8'h80};
        send_string(END_LAST);                          // stray continuation as lead
        str_buf = '{8'hC2, 8'h41};
        send_string(END_LAST);                          // bad continuation
        str_buf = '{8'hE2, 8'h82};
        send_string(END_EMPTY);                         // open sequence closed by empty item
        str_buf = '{8'hE2, 8'h82};
        send_string(END_LAST);                          // cut off at the last byte
        str_buf = '{8'h41};
        send_string(END_BOTH);                          // last and empty together
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin lim = 16'hFFFF; nonempty = 1'b0; end
                1: begin lim = 16'd0; nonempty = 1'b1; end
                2: begin lim = 16'($urandom_range(1, 12)); nonempty = 1'b1; end
                3: begin lim = 16'($urandom_range(2, 30)); nonempty = 1'b0; end
                4: begin lim = 16'($urandom_range(13, 40)); nonempty = 1'($urandom_range(0, 1)); end
                default: begin
                    lim      = 16'hFFFF;
                    nonempty = 1'b1;
                    quiet    = 1'b1;                    // full rate to finish
                end
            endcase
            cfg_write(utf8v_pkg::REG_MAX_LENGTH, {16'd0, lim});
            cfg_write(utf8v_pkg::REG_REQUIRE_NONEMPTY, {31'd0, nonempty});
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("covered %0d byte items and %0d verdicts (%0d valid) over 7 register settings",
                 n_accepted, n_checked, n_valid);
        $display("error kinds reached, one bit per kind from 9 down to 0: %b", kinds_seen);
        if (n_fail == 0 && verdict_q.size() == 0) begin
            $display("utf8_text_validator_unit regression: pass");
        end else begin
            $display("%0d failures, %0d verdicts missing", n_fail, verdict_q.size());
            $display("utf8_text_validator_unit regression: fail");
        end
        $finish;
    end

endmodule
